FILE: sv/rmc_pkg.sv
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared widths, command codes and controller/datapath structs for the
// range mountain check block.
// ----------------------------------------------------------------------------
package rmc_pkg;

    localparam int POS_W         = 10;
    localparam int DATA_W        = 32;
    localparam int DEFAULT_DEPTH = 1024;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic load_we;
        logic start;
        logic issue;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic empty_range;
        logic issue_last;
        logic rd_last_vld;
        logic out_free;
    } t_dp_status;

endpackage

FILE: sv/rmc_if.sv
// ----------------------------------------------------------------------------
// rmc_in_if / rmc_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface rmc_in_if
    import rmc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     cmd;
    logic [POS_W-1:0]         load_index;
    logic signed [DATA_W-1:0] load_value;
    logic [POS_W-1:0]         query_left;
    logic [POS_W-1:0]         query_right;

    modport source (
        output valid, cmd, load_index, load_value, query_left, query_right,
        input  ready
    );
    modport sink (
        input  valid, cmd, load_index, load_value, query_left, query_right,
        output ready
    );
endinterface

interface rmc_out_if;
    logic valid;
    logic ready;
    logic is_mountain;

    modport source (output valid, is_mountain, input ready);
    modport sink (input valid, is_mountain, output ready);
endinterface

FILE: sv/rmc_ctrl.sv
// ----------------------------------------------------------------------------
// rmc_ctrl
// Controller: accepts transactions, sequences the range walk and hands the
// answer to the output register.
// ----------------------------------------------------------------------------
module rmc_ctrl
    import rmc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_cmd,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        o_cmd.load_we = 1'b0;
        o_cmd.start   = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.push    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = i_status.empty_range ? S_FINISH : S_WALK;
                    end
                end
            end
            S_WALK: begin
                o_cmd.issue = 1'b1;
                if (i_status.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_status.rd_last_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/rmc_dp.sv
// ----------------------------------------------------------------------------
// rmc_dp
// Datapath: element memory, walk pointer, neighbor compare and output
// register.
// ----------------------------------------------------------------------------
module rmc_dp
    import rmc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [POS_W-1:0]         i_load_index,
    input  logic signed [DATA_W-1:0] i_load_value,
    input  logic [POS_W-1:0]         i_query_left,
    input  logic [POS_W-1:0]         i_query_right,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic                     o_out_is_mountain
);

    localparam int AW = $clog2(DEPTH);

    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic [POS_W-1:0]         r_pos;
    logic [POS_W-1:0]         r_right;
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_rd_ok;
    logic                     r_rd_vld;
    logic                     r_rd_last;
    logic signed [DATA_W-1:0] r_prev;
    logic                     r_first;
    logic                     r_falling;
    logic                     r_fail;
    logic                     r_out_valid;
    logic                     r_out_data;
    logic signed [DATA_W-1:0] w_cur;
    logic                     w_load_ok;

    assign w_load_ok = (32'(i_load_index) < 32'(DEPTH));
    assign w_cur     = r_rd_ok ? r_rd_data : '0;

    assign o_status.empty_range = (i_query_left >= i_query_right);
    assign o_status.issue_last  = (r_pos == r_right);
    assign o_status.rd_last_vld = r_rd_vld && r_rd_last;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_load_ok) begin
            r_mem[AW'(i_load_index)] <= i_load_value;
        end
        r_rd_data <= r_mem[AW'(r_pos)];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos   <= i_query_left;
            r_right <= i_query_right;
        end else if (i_cmd.issue && (r_pos != r_right)) begin
            r_pos <= r_pos + 1'b1;
        end
        r_rd_ok   <= (32'(r_pos) < 32'(DEPTH));
        r_rd_last <= (r_pos == r_right);
        if (r_rd_vld) begin
            r_prev <= w_cur;
        end
        if (i_cmd.push) begin
            r_out_data <= !r_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld    <= 1'b0;
            r_first     <= 1'b1;
            r_falling   <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_first   <= 1'b1;
                r_falling <= 1'b0;
                r_fail    <= 1'b0;
            end else if (r_rd_vld) begin
                r_first <= 1'b0;
                if (!r_first) begin
                    if (!r_falling) begin
                        if (r_prev > w_cur) begin
                            r_falling <= 1'b1;
                        end
                    end else if (r_prev < w_cur) begin
                        r_fail <= 1'b1;
                    end
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_is_mountain = r_out_data;

endmodule

FILE: sv/range_mountain_check_core.sv
// ----------------------------------------------------------------------------
// range_mountain_check_core
// Element store with range queries that answer whether a subarray never
// rises again once it has started to fall.
// ----------------------------------------------------------------------------
// A load transaction with an index below DEPTH writes one signed element
// and gives no result; back-to-back loads are taken every cycle. A query with
// left below right walks the elements from left to right through the single
// read port of the element memory, which delivers one element per cycle of
// the walk, then drains the last read and waits for a free output register;
// a query with left at or above right goes straight to that wait. One query is
// in flight at a time, and the next transaction is taken once its answer is in
// the output register. Entries never loaded read as undefined.
module range_mountain_check_core
    import rmc_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rmc_in_if.sink   i_item,
    rmc_out_if.source o_result
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_item.ready = w_in_ready;

    rmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_cmd   (i_item.cmd),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rmc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load_index      (i_item.load_index),
        .i_load_value      (i_item.load_value),
        .i_query_left      (i_item.query_left),
        .i_query_right     (i_item.query_right),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_out_ready       (o_result.ready),
        .o_out_valid       (o_result.valid),
        .o_out_is_mountain (o_result.is_mountain)
    );

endmodule
